[rtl/assert_macros.svh]
// Assertion macros used by the deframer back end (dfr_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DFR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DFR_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define DFR_ASSERT(label, clk, rst_n, prop, msg)
`define DFR_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

[rtl/dfr_pkg.sv]
// Types, constants and the CRC step shared by the telemetry deframer.
`default_nettype none
package dfr_pkg;

    localparam int MAX_PAYLOAD   = 32;
    localparam int TELEMETRY_LEN = 24;
    localparam int IDX_W         = 5;
    localparam int MEM_AW        = IDX_W + 1;
    localparam int CNT_W         = 6;
    localparam int CFG_IDX_W     = 3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [CFG_IDX_W-1:0] CFG_MARK_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND        = 3'd3;

    typedef enum logic [1:0] {
        STAT_GOOD  = 2'd0,
        STAT_CRC   = 2'd1,
        STAT_PROTO = 2'd2,
        STAT_LEN   = 2'd3
    } frame_status_t;

    typedef enum logic [3:0] {
        FS_HUNT,
        FS_MARK2,
        FS_VER,
        FS_KIND,
        FS_SEQ,
        FS_LEN,
        FS_PAY,
        FS_CRC_LO,
        FS_CRC_HI
    } front_state_t;

    typedef struct packed {
        frame_status_t status;
        logic          bank;
    } job_t;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } wr_req_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[rtl/telemetry_frame_deframer_top.sv]
// Top level of the telemetry frame deframer.
//
// Usage:
//   rx channel (rx_valid/rx_ready/rx_byte) takes one received byte per transfer.
//   The block hunts for the two start-mark bytes, parses version, kind,
//   sequence and length, stores the payload and checks a CRC-16/Modbus sent
//   low byte first. Frames with a length above 32 are dropped without result.
//   At the CRC high byte a frame yields one status result (crc, protocol or
//   length error) or, for a good telemetry frame, 24 payload results with the
//   last one marked. Counters in each result wrap at 2^32.
//   Throughput: one byte per cycle on rx and one result per cycle, while
//   rx_ready and res_ready are high. A frame's first result passes the job
//   queue and the result register. rx_ready drops while the two-entry job
//   queue between the parser and the result sequencer is full; two payload
//   banks let the next frame be parsed while a good frame drains. A receiver
//   stall holds the result register and backs up through the queue to rx.
//   Reset restores the default marks, version and kind, clears the counters
//   and starts the hunt; no clearing pass. Configure only when idle.
`default_nettype none
module telemetry_frame_deframer_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [dfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    input  wire logic                          rx_valid,
    output logic                               rx_ready,
    input  wire logic [7:0]                    rx_byte,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output logic [1:0]                         frame_status,
    output logic [7:0]                         payload_byte,
    output logic [4:0]                         byte_index,
    output logic                               last_of_frame,
    output logic [31:0]                        good_frame_count,
    output logic [31:0]                        crc_error_count,
    output logic [31:0]                        protocol_error_count
);

    dfr_pkg::job_t    push_job;
    dfr_pkg::job_t    head;
    dfr_pkg::wr_req_t mem_wr;
    logic             q_push;
    logic             q_pop;
    logic             q_empty;
    logic             q_full;

    dfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_byte   (rx_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job),
        .mem_wr    (mem_wr)
    );

    dfr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    dfr_back u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .mem_wr               (mem_wr),
        .head                 (head),
        .q_empty              (q_empty),
        .q_pop                (q_pop),
        .res_valid            (res_valid),
        .res_ready            (res_ready),
        .frame_status         (frame_status),
        .payload_byte         (payload_byte),
        .byte_index           (byte_index),
        .last_of_frame        (last_of_frame),
        .good_frame_count     (good_frame_count),
        .crc_error_count      (crc_error_count),
        .protocol_error_count (protocol_error_count)
    );

endmodule
`default_nettype wire

[rtl/dfr_front.sv]
// Front end: configuration registers, start-mark hunt, header parse, CRC and frame judgment.
`default_nettype none
module dfr_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [dfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [7:0]                     cfg_data,
    input  wire logic                           rx_valid,
    output logic                                rx_ready,
    input  wire logic [7:0]                     rx_byte,
    input  wire logic                           q_full,
    output logic                                q_push,
    output dfr_pkg::job_t                       q_job,
    output dfr_pkg::wr_req_t                    mem_wr
);

    logic [7:0] mark1_reg, mark2_reg, version_reg, kind_reg;

    dfr_pkg::front_state_t          state_reg, state_next;
    logic [15:0]                    crc_reg, crc_next;
    logic [7:0]                     ver_reg, ver_next;
    logic [7:0]                     kd_reg, kd_next;
    logic [7:0]                     len_reg, len_next;
    logic [7:0]                     crc_lo_reg, crc_lo_next;
    logic [dfr_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                           bank_reg, bank_next;
    logic                           accept;
    logic [15:0]                    crc_step;
    logic [15:0]                    rx_crc;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mark1_reg   <= 8'hAA;
            mark2_reg   <= 8'h55;
            version_reg <= 8'h01;
            kind_reg    <= 8'h02;
        end
        else if (cfg_write) begin
            case (cfg_index)
                dfr_pkg::CFG_MARK_FIRST:  mark1_reg   <= cfg_data;
                dfr_pkg::CFG_MARK_SECOND: mark2_reg   <= cfg_data;
                dfr_pkg::CFG_VERSION:     version_reg <= cfg_data;
                dfr_pkg::CFG_KIND:        kind_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign rx_ready = !q_full;
    assign accept   = rx_valid && rx_ready;
    assign crc_step = dfr_pkg::crc_feed(crc_reg, rx_byte);
    assign rx_crc   = {rx_byte, crc_lo_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= dfr_pkg::FS_HUNT;
            crc_reg   <= dfr_pkg::CRC_INIT;
            cnt_reg   <= '0;
            bank_reg  <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            crc_reg   <= crc_next;
            cnt_reg   <= cnt_next;
            bank_reg  <= bank_next;
        end
    end

    always_ff @(posedge clk) begin
        ver_reg    <= ver_next;
        kd_reg     <= kd_next;
        len_reg    <= len_next;
        crc_lo_reg <= crc_lo_next;
    end

    always_comb begin
        state_next  = state_reg;
        crc_next    = crc_reg;
        ver_next    = ver_reg;
        kd_next     = kd_reg;
        len_next    = len_reg;
        crc_lo_next = crc_lo_reg;
        cnt_next    = cnt_reg;
        bank_next   = bank_reg;
        q_push      = 1'b0;
        q_job       = '{status: dfr_pkg::STAT_GOOD, bank: bank_reg};
        mem_wr      = '{en: 1'b0, addr: {bank_reg, cnt_reg[dfr_pkg::IDX_W-1:0]},
                        data: rx_byte};
        if (accept) begin
            unique case (state_reg)
                dfr_pkg::FS_HUNT: begin
                    if (rx_byte == mark1_reg)
                        state_next = dfr_pkg::FS_MARK2;
                end
                dfr_pkg::FS_MARK2: begin
                    if (rx_byte == mark2_reg) begin
                        state_next = dfr_pkg::FS_VER;
                        crc_next   = dfr_pkg::CRC_INIT;
                    end
                    else if (rx_byte != mark1_reg) begin
                        state_next = dfr_pkg::FS_HUNT;
                    end
                end
                dfr_pkg::FS_VER: begin
                    ver_next   = rx_byte;
                    crc_next   = crc_step;
                    state_next = dfr_pkg::FS_KIND;
                end
                dfr_pkg::FS_KIND: begin
                    kd_next    = rx_byte;
                    crc_next   = crc_step;
                    state_next = dfr_pkg::FS_SEQ;
                end
                dfr_pkg::FS_SEQ: begin
                    crc_next   = crc_step;
                    state_next = dfr_pkg::FS_LEN;
                end
                dfr_pkg::FS_LEN: begin
                    len_next = rx_byte;
                    crc_next = crc_step;
                    cnt_next = '0;
                    // drop oversized frames silently
                    if (rx_byte > 8'(dfr_pkg::MAX_PAYLOAD))
                        state_next = dfr_pkg::FS_HUNT;
                    else if (rx_byte == 8'd0)
                        state_next = dfr_pkg::FS_CRC_LO;
                    else
                        state_next = dfr_pkg::FS_PAY;
                end
                dfr_pkg::FS_PAY: begin
                    mem_wr.en = 1'b1;
                    crc_next  = crc_step;
                    cnt_next  = cnt_reg + dfr_pkg::CNT_W'(1);
                    if (8'(cnt_next) == len_reg)
                        state_next = dfr_pkg::FS_CRC_LO;
                end
                dfr_pkg::FS_CRC_LO: begin
                    crc_lo_next = rx_byte;
                    state_next  = dfr_pkg::FS_CRC_HI;
                end
                dfr_pkg::FS_CRC_HI: begin
                    state_next = dfr_pkg::FS_HUNT;
                    q_push     = 1'b1;
                    if (rx_crc != crc_reg)
                        q_job.status = dfr_pkg::STAT_CRC;
                    else if (ver_reg != version_reg || kd_reg != kind_reg)
                        q_job.status = dfr_pkg::STAT_PROTO;
                    else if (len_reg != 8'(dfr_pkg::TELEMETRY_LEN))
                        q_job.status = dfr_pkg::STAT_LEN;
                    else
                        bank_next = ~bank_reg;
                end
                default: state_next = dfr_pkg::FS_HUNT;
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/dfr_queue.sv]
// Two-entry job queue between the front end and the result sequencer.
`default_nettype none
module dfr_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire dfr_pkg::job_t push_job,
    input  wire logic          pop,
    output dfr_pkg::job_t      head,
    output logic               empty,
    output logic               full
);

    dfr_pkg::job_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule
`default_nettype wire

[rtl/dfr_back.sv]
// Back end: payload memory, result sequencer, frame counters and result register.
`include "assert_macros.svh"
`default_nettype none
module dfr_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire dfr_pkg::wr_req_t          mem_wr,
    input  wire dfr_pkg::job_t             head,
    input  wire logic                      q_empty,
    output logic                           q_pop,
    output logic                           res_valid,
    input  wire logic                      res_ready,
    output logic [1:0]                     frame_status,
    output logic [7:0]                     payload_byte,
    output logic [dfr_pkg::IDX_W-1:0]      byte_index,
    output logic                           last_of_frame,
    output logic [31:0]                    good_frame_count,
    output logic [31:0]                    crc_error_count,
    output logic [31:0]                    protocol_error_count
);

    logic [7:0]                  mem [2**dfr_pkg::MEM_AW];
    logic [dfr_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                        valid_reg, valid_next;
    dfr_pkg::frame_status_t      status_reg;
    logic [7:0]                  data_reg;
    logic [dfr_pkg::IDX_W-1:0]   index_reg;
    logic                        last_reg;
    logic [31:0]                 good_reg, good_next;
    logic [31:0]                 crcerr_reg, crcerr_next;
    logic [31:0]                 proto_reg, proto_next;
    logic                        load;
    logic                        is_good;
    logic                        is_last;
    logic [dfr_pkg::MEM_AW-1:0]  rd_addr;

    assign load    = (!valid_reg || res_ready) && !q_empty;
    assign is_good = (head.status == dfr_pkg::STAT_GOOD);
    assign is_last = !is_good || (idx_reg == dfr_pkg::IDX_W'(dfr_pkg::TELEMETRY_LEN - 1));
    assign q_pop   = load && is_last;
    assign rd_addr = {head.bank, idx_reg};

    always_comb begin
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        good_next   = good_reg;
        crcerr_next = crcerr_reg;
        proto_next  = proto_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = is_last ? '0 : idx_reg + dfr_pkg::IDX_W'(1);
            if (idx_reg == '0) begin
                case (head.status)
                    dfr_pkg::STAT_GOOD:  good_next   = good_reg + 32'd1;
                    dfr_pkg::STAT_CRC:   crcerr_next = crcerr_reg + 32'd1;
                    dfr_pkg::STAT_PROTO: proto_next  = proto_reg + 32'd1;
                    default: ;
                endcase
            end
        end
        else if (res_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            idx_reg    <= '0;
            valid_reg  <= 1'b0;
            good_reg   <= '0;
            crcerr_reg <= '0;
            proto_reg  <= '0;
        end
        else begin
            idx_reg    <= idx_next;
            valid_reg  <= valid_next;
            good_reg   <= good_next;
            crcerr_reg <= crcerr_next;
            proto_reg  <= proto_next;
        end
    end

    always_ff @(posedge clk) begin
        if (mem_wr.en)
            mem[mem_wr.addr] <= mem_wr.data;
        if (load) begin
            data_reg   <= is_good ? mem[rd_addr] : 8'h00;
            status_reg <= head.status;
            index_reg  <= is_good ? idx_reg : '0;
            last_reg   <= is_last;
        end
    end

    assign res_valid            = valid_reg;
    assign frame_status         = status_reg;
    assign payload_byte         = data_reg;
    assign byte_index           = index_reg;
    assign last_of_frame        = last_reg;
    assign good_frame_count     = good_reg;
    assign crc_error_count      = crcerr_reg;
    assign protocol_error_count = proto_reg;

    `DFR_ASSERT(a_good_last_idx, clk, rst_n, (valid_reg && last_reg && status_reg == dfr_pkg::STAT_GOOD) |-> (index_reg == dfr_pkg::IDX_W'(dfr_pkg::TELEMETRY_LEN - 1)), "good frame ends at wrong index")
    `DFR_ASSERT(a_status_single, clk, rst_n, (valid_reg && status_reg != dfr_pkg::STAT_GOOD) |-> (last_reg && data_reg == 8'h00 && index_reg == '0), "status result not a lone zero result")
    `DFR_ASSERT(a_good_step, clk, rst_n, !$stable(good_reg) |-> (good_reg == $past(good_reg) + 32'd1 && $past(load)), "good count moved without a loaded frame")
    `DFR_ASSERT_NEVER(a_pop_empty, clk, rst_n, q_pop && q_empty, "pop from empty queue")

endmodule
`default_nettype wire
